### hw/rtl/falc_pkg.sv
// Shared types and constants of the fully associative LFU cache tag unit.
package falc_pkg;

	localparam int ROW_FIELD_BITS = 3;
	localparam int TOTAL_BITS     = 32;
	localparam int FILL_COUNT     = 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic resolved;
		logic scan_last;
	} status_t;

endpackage

### hw/rtl/falc_ctrl.sv
// Controller state machine of the fully associative LFU cache tag unit.
module falc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  falc_pkg::status_t status,
	output falc_pkg::cmd_t    cmd,
	output logic              busy
);
	import falc_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_nx = status.resolved ? ST_IDLE : ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/falc_dpath.sv
// Datapath of the fully associative LFU cache tag unit: rows, victim scan, totals.
module falc_dpath #(
	parameter int ROWS       = 8,
	parameter int ADDR_BITS  = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  falc_pkg::cmd_t                      cmd,
	input  logic [ADDR_BITS-1:0]                address,
	output falc_pkg::status_t                   status,
	output logic                                done,
	output logic                                was_hit,
	output logic [falc_pkg::ROW_FIELD_BITS-1:0] row_used,
	output logic [falc_pkg::TOTAL_BITS-1:0]     hit_total,
	output logic [falc_pkg::TOTAL_BITS-1:0]     miss_total
);
	import falc_pkg::*;

	localparam int IDX_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [IDX_BITS-1:0]   LAST_ROW  = IDX_BITS'(ROWS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_FILL = COUNT_BITS'(FILL_COUNT);

	logic [ROWS-1:0]       valid_q;
	logic [ADDR_BITS-1:0]  tag_q   [ROWS];
	logic [COUNT_BITS-1:0] count_q [ROWS];
	logic [ADDR_BITS-1:0]  addr_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   victim_q;
	logic [COUNT_BITS-1:0] best_q;
	logic                  done_q;
	logic                  was_hit_q;
	logic [ROW_FIELD_BITS-1:0] row_used_q;
	logic [TOTAL_BITS-1:0] hit_total_q;
	logic [TOTAL_BITS-1:0] miss_total_q;

	logic                  hit;
	logic [IDX_BITS-1:0]   hit_row;
	logic                  have_free;
	logic [IDX_BITS-1:0]   free_row;
	logic [COUNT_BITS-1:0] cand;
	logic                  take;
	logic [IDX_BITS-1:0]   victim_nx;
	logic [COUNT_BITS-1:0] best_nx;
	logic                  scan_last;
	logic                  commit_hit;
	logic                  commit_fill;
	logic                  scan_init;
	logic [IDX_BITS-1:0]   fill_row;
	logic [IDX_BITS-1:0]   res_row;
	logic [IDX_BITS+ROW_FIELD_BITS-1:0] res_row_ext;

	always_comb begin
		hit       = 1'b0;
		hit_row   = '0;
		have_free = 1'b0;
		free_row  = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (valid_q[r] && (tag_q[r] == addr_q)) begin
				hit     = 1'b1;
				hit_row = IDX_BITS'(r);
			end
			if (!valid_q[r]) begin
				have_free = 1'b1;
				free_row  = IDX_BITS'(r);
			end
		end
	end

	always_comb begin
		cand        = count_q[idx_q];
		take        = (cand <= best_q) && ((victim_q != '0) || (cand < best_q));
		victim_nx   = take ? idx_q : victim_q;
		best_nx     = take ? cand : best_q;
		scan_last   = (idx_q == LAST_ROW);
		commit_hit  = cmd.lookup && hit;
		commit_fill = (cmd.lookup && !hit && have_free) || (cmd.scan && scan_last);
		scan_init   = cmd.lookup && !hit && !have_free;
		fill_row    = cmd.lookup ? free_row : victim_nx;
		res_row     = commit_hit ? hit_row : fill_row;
		res_row_ext = {{ROW_FIELD_BITS{1'b0}}, res_row};
	end

	assign status.resolved  = hit || have_free;
	assign status.scan_last = scan_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			done_q       <= 1'b0;
			hit_total_q  <= '0;
			miss_total_q <= '0;
		end else begin
			done_q <= commit_hit || commit_fill;
			if (commit_hit && (hit_total_q != '1)) begin
				hit_total_q <= hit_total_q + TOTAL_BITS'(1);
			end
			if (commit_fill) begin
				valid_q[fill_row] <= 1'b1;
				if (miss_total_q != '1) begin
					miss_total_q <= miss_total_q + TOTAL_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= address;
		end
		if (commit_hit && (count_q[hit_row] != COUNT_MAX)) begin
			count_q[hit_row] <= count_q[hit_row] + COUNT_BITS'(1);
		end
		if (commit_fill) begin
			tag_q[fill_row]   <= addr_q;
			count_q[fill_row] <= COUNT_FILL;
		end
		if (commit_hit || commit_fill) begin
			was_hit_q  <= commit_hit;
			row_used_q <= res_row_ext[ROW_FIELD_BITS-1:0];
		end
		if (scan_init) begin
			idx_q    <= IDX_BITS'(1);
			victim_q <= '0;
			best_q   <= count_q[0];
		end else if (cmd.scan) begin
			idx_q    <= idx_q + IDX_BITS'(1);
			victim_q <= victim_nx;
			best_q   <= best_nx;
		end
	end

	assign done       = done_q;
	assign was_hit    = was_hit_q;
	assign row_used   = row_used_q;
	assign hit_total  = hit_total_q;
	assign miss_total = miss_total_q;

endmodule

### hw/rtl/fully_assoc_lfu_cache_tags_unit.sv
// Top level of the fully associative LFU cache tag unit.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  request   | start, busy            | address
//  result    | done (one-cycle strobe)| was_hit, row_used, hit_total, miss_total
//
//  Hit, or miss with a free row: the unit goes from LOOKUP back to IDLE and done is
//  registered; the next request may be taken in the cycle that done is high.
//  Miss with all rows valid: a victim scan follows LOOKUP; it reads one row's
//  use count per cycle over rows 1 to ROWS-1.
//  Reset clears all row valid bits and both totals at once; no clearing pass.
//  The receiver cannot stall; each result is shown for exactly one cycle.
module fully_assoc_lfu_cache_tags_unit #(
	parameter int ROWS       = 8,
	parameter int ADDR_BITS  = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ADDR_BITS-1:0]                address,
	output logic                                done,
	output logic                                was_hit,
	output logic [falc_pkg::ROW_FIELD_BITS-1:0] row_used,
	output logic [falc_pkg::TOTAL_BITS-1:0]     hit_total,
	output logic [falc_pkg::TOTAL_BITS-1:0]     miss_total
);
	import falc_pkg::*;

	cmd_t    cmd;
	status_t status;

	falc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	falc_dpath #(
		.ROWS       (ROWS),
		.ADDR_BITS  (ADDR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.address    (address),
		.status     (status),
		.done       (done),
		.was_hit    (was_hit),
		.row_used   (row_used),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

endmodule

### hw/rtl/falc_checker.sv
// Port-level assertions of the fully associative LFU cache tag unit, with bind.
module falc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic                                was_hit,
	input logic [falc_pkg::TOTAL_BITS-1:0]     hit_total,
	input logic [falc_pkg::TOTAL_BITS-1:0]     miss_total
);
	import falc_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but unit not busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in progress");

	a_hit_keeps_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_hit) |-> ($stable(miss_total) && (hit_total != '0)))
		else $error("hit result changed miss total");

	a_miss_keeps_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !was_hit) |-> ($stable(hit_total) && (miss_total != '0)))
		else $error("miss result changed hit total");

endmodule

bind fully_assoc_lfu_cache_tags_unit falc_checker u_falc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.was_hit    (was_hit),
	.hit_total  (hit_total),
	.miss_total (miss_total)
);
